[src/ppzd_pkg.sv]
// ----------------------------------------------------------------------------
// ppzd_pkg
// Shared codes for the price pivot zone detector.
// ----------------------------------------------------------------------------
package ppzd_pkg;
    localparam logic [1:0] PIVOT_NONE = 2'd0;
    localparam logic [1:0] PIVOT_HIGH = 2'd1;
    localparam logic [1:0] PIVOT_LOW  = 2'd2;

    localparam logic [1:0] END_OPEN = 2'd0;
    localparam logic [1:0] END_UP   = 2'd1;
    localparam logic [1:0] END_DOWN = 2'd2;
endpackage
// ----------------------------------------------------------------------------

[src/ppzd_bar_if.sv]
// ----------------------------------------------------------------------------
// ppzd_bar_if
// Valid/ready channel carrying one price bar per beat.
// ----------------------------------------------------------------------------
interface ppzd_bar_if #(
    parameter int PRICE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            pivot_kind;
    logic [PRICE_BITS-1:0] bar_high;
    logic [PRICE_BITS-1:0] bar_low;
    logic                  series_end;

    modport source (output valid, pivot_kind, bar_high, bar_low, series_end, input ready);
    modport sink   (input valid, pivot_kind, bar_high, bar_low, series_end, output ready);
endinterface
// ----------------------------------------------------------------------------

[src/ppzd_zone_if.sv]
// ----------------------------------------------------------------------------
// ppzd_zone_if
// Valid/ready channel carrying one finished zone per beat.
// ----------------------------------------------------------------------------
interface ppzd_zone_if #(
    parameter int INDEX_BITS = 24,
    parameter int PRICE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] zone_start_bar;
    logic [INDEX_BITS-1:0] zone_end_bar;
    logic [PRICE_BITS-1:0] zone_top;
    logic [PRICE_BITS-1:0] zone_bottom;
    logic [PRICE_BITS-1:0] inner_peak;
    logic [PRICE_BITS-1:0] inner_trough;
    logic                  middle_dir_down;
    logic [1:0]            ending_kind;

    modport source (output valid, zone_start_bar, zone_end_bar, zone_top, zone_bottom,
                    inner_peak, inner_trough, middle_dir_down, ending_kind, input ready);
    modport sink   (input valid, zone_start_bar, zone_end_bar, zone_top, zone_bottom,
                    inner_peak, inner_trough, middle_dir_down, ending_kind, output ready);
endinterface
// ----------------------------------------------------------------------------

[src/price_pivot_zone_detector.sv]
// ----------------------------------------------------------------------------
// price_pivot_zone_detector
// Joins pivot bars into segments and reports overlapping segment zones.
// ----------------------------------------------------------------------------
// Usage:
//   i_bar is a valid/ready sink, one bar per beat. o_zone is a valid/ready
//   source with at most one zone per bar.
//   Each accepted bar is folded into the segment window in the cycle it is
//   taken; a zone it closes is registered and is on o_zone the next cycle.
//   Throughput is one bar per cycle while o_zone does not stall. A single
//   output register holds the zone; i_bar.ready drops only while it is full
//   and the sink is not taking it, so a bar is taken in the same cycle the
//   held beat leaves. The rate is set by the combinational window update.
//   A bar with series_end set closes its segment, emits any still open zone
//   with ending open, then returns all state to reset, bar index 0.
//   Reset (i_rst_n low, synchronous) clears the window, the bar counter and
//   the output valid.
// ----------------------------------------------------------------------------
module price_pivot_zone_detector #(
    parameter int INDEX_BITS = 24,
    parameter int PRICE_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppzd_bar_if.sink    i_bar,
    ppzd_zone_if.source o_zone
);
    import ppzd_pkg::*;

    typedef logic [INDEX_BITS-1:0] t_idx;
    typedef logic [PRICE_BITS-1:0] t_prc;

    typedef struct packed {
        t_idx s; t_idx e; t_prc hi; t_prc lo;
        t_prc inmax; t_prc inmin; t_prc ehi; t_prc elo;
        logic down;
    } t_seg;

    typedef struct packed {
        t_idx s; t_idx e; t_prc top; t_prc bot;
        t_prc gg; t_prc dd; t_prc ehi; t_prc elo;
        logic down;
    } t_zone;

    localparam t_prc PMAX = {PRICE_BITS{1'b1}};

    // window and pivot state
    t_idx  r_cnt, n_cnt;
    logic  r_pv, n_pv;
    logic  r_plow, n_plow;
    t_idx  r_pidx, n_pidx;
    t_prc  r_phi, n_phi, r_plo, n_plo;
    t_prc  r_gmax, n_gmax, r_gmin, n_gmin;
    t_seg  r_w0, r_w1, n_w0, n_w1;
    logic [1:0] r_wc, n_wc;
    logic  r_za, n_za;
    t_zone r_z, n_z;

    // output register
    logic  r_ov;
    t_zone r_oz, n_oz;
    logic [1:0] r_ok, n_ok;
    logic  n_emit;

    logic  take;
    assign i_bar.ready = !r_ov || o_zone.ready;
    assign take = i_bar.valid && i_bar.ready;

    t_seg  g;
    logic  is_piv;
    t_prc  nl, nh, ol, oh;

    always_comb begin
        is_piv = (i_bar.pivot_kind == PIVOT_HIGH) || (i_bar.pivot_kind == PIVOT_LOW);
        g.s     = r_pidx;
        g.e     = r_cnt;
        g.hi    = (r_phi > i_bar.bar_high) ? r_phi : i_bar.bar_high;
        g.lo    = (r_plo < i_bar.bar_low) ? r_plo : i_bar.bar_low;
        g.inmax = r_gmax;
        g.inmin = r_gmin;
        g.ehi   = i_bar.bar_high;
        g.elo   = i_bar.bar_low;
        g.down  = !r_plow;

        n_cnt = r_cnt + t_idx'(1);
        n_pv = r_pv; n_plow = r_plow; n_pidx = r_pidx; n_phi = r_phi; n_plo = r_plo;
        n_gmax = r_gmax; n_gmin = r_gmin;
        n_w0 = r_w0; n_w1 = r_w1; n_wc = r_wc;
        n_za = r_za; n_z = r_z;
        n_emit = 1'b0; n_oz = r_z; n_ok = END_OPEN;

        nl = (r_z.bot > g.lo) ? r_z.bot : g.lo;
        nh = (r_z.top < g.hi) ? r_z.top : g.hi;
        ol = '0; oh = '0;

        if (is_piv) begin
            if (r_pv) begin
                if (r_za) begin
                    if (nl <= nh) begin
                        n_z.gg = r_z.gg;
                        if (r_z.ehi > n_z.gg) n_z.gg = r_z.ehi;
                        if (g.inmax > n_z.gg) n_z.gg = g.inmax;
                        n_z.dd = r_z.dd;
                        if (r_z.elo < n_z.dd) n_z.dd = r_z.elo;
                        if (g.inmin < n_z.dd) n_z.dd = g.inmin;
                        n_z.bot = nl; n_z.top = nh; n_z.e = g.e;
                        n_z.ehi = g.ehi; n_z.elo = g.elo;
                    end else begin
                        n_emit = 1'b1;
                        n_oz = r_z;
                        if (g.hi < r_z.bot) n_ok = END_DOWN;
                        else if (g.lo > r_z.top) n_ok = END_UP;
                        n_za = 1'b0;
                        n_w0 = g;
                        n_wc = 2'd1;
                    end
                end else if (r_wc == 2'd0) begin
                    n_w0 = g; n_wc = 2'd1;
                end else if (r_wc == 2'd1) begin
                    n_w1 = g; n_wc = 2'd2;
                end else begin
                    // third segment: test the triple r_w0, r_w1, g
                    ol = (r_w0.lo > r_w1.lo) ? r_w0.lo : r_w1.lo;
                    if (g.lo > ol) ol = g.lo;
                    oh = (r_w0.hi < r_w1.hi) ? r_w0.hi : r_w1.hi;
                    if (g.hi < oh) oh = g.hi;
                    if (ol <= oh) begin
                        n_z.s = r_w0.s; n_z.e = g.e; n_z.top = oh; n_z.bot = ol;
                        n_z.gg = (r_w0.inmax > r_w0.ehi) ? r_w0.inmax : r_w0.ehi;
                        if (r_w1.inmax > n_z.gg) n_z.gg = r_w1.inmax;
                        if (r_w1.ehi > n_z.gg) n_z.gg = r_w1.ehi;
                        if (g.inmax > n_z.gg) n_z.gg = g.inmax;
                        n_z.dd = (r_w0.inmin < r_w0.elo) ? r_w0.inmin : r_w0.elo;
                        if (r_w1.inmin < n_z.dd) n_z.dd = r_w1.inmin;
                        if (r_w1.elo < n_z.dd) n_z.dd = r_w1.elo;
                        if (g.inmin < n_z.dd) n_z.dd = g.inmin;
                        n_z.ehi = g.ehi; n_z.elo = g.elo; n_z.down = r_w1.down;
                        n_za = 1'b1; n_wc = 2'd0;
                    end else begin
                        n_w0 = r_w1; n_w1 = g; n_wc = 2'd2;
                    end
                end
            end
            n_pv = 1'b1; n_plow = (i_bar.pivot_kind == PIVOT_LOW);
            n_pidx = r_cnt; n_phi = i_bar.bar_high; n_plo = i_bar.bar_low;
            n_gmax = '0; n_gmin = PMAX;
        end else begin
            if (i_bar.bar_high > r_gmax) n_gmax = i_bar.bar_high;
            if (i_bar.bar_low < r_gmin) n_gmin = i_bar.bar_low;
        end

        if (i_bar.series_end && n_za && !n_emit) begin
            n_emit = 1'b1; n_oz = n_z; n_ok = END_OPEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_pv <= 1'b0; r_wc <= 2'd0; r_za <= 1'b0;
            r_gmax <= '0; r_gmin <= PMAX; r_ov <= 1'b0;
        end else begin
            // held beat stays until taken; a new zone may replace it the same edge
            r_ov <= (take && n_emit) || (r_ov && !o_zone.ready);
            if (take) begin
                if (i_bar.series_end) begin
                    r_cnt <= '0; r_pv <= 1'b0; r_wc <= 2'd0; r_za <= 1'b0;
                    r_gmax <= '0; r_gmin <= PMAX;
                end else begin
                    r_cnt <= n_cnt; r_pv <= n_pv; r_wc <= n_wc; r_za <= n_za;
                    r_gmax <= n_gmax; r_gmin <= n_gmin;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_plow <= n_plow; r_pidx <= n_pidx; r_phi <= n_phi; r_plo <= n_plo;
            r_w0 <= n_w0; r_w1 <= n_w1; r_z <= n_z;
            if (n_emit) begin
                r_oz <= n_oz; r_ok <= n_ok;
            end
        end
    end

    assign o_zone.valid           = r_ov;
    assign o_zone.zone_start_bar  = r_oz.s;
    assign o_zone.zone_end_bar    = r_oz.e;
    assign o_zone.zone_top        = r_oz.top;
    assign o_zone.zone_bottom     = r_oz.bot;
    assign o_zone.inner_peak      = r_oz.gg;
    assign o_zone.inner_trough    = r_oz.dd;
    assign o_zone.middle_dir_down = r_oz.down;
    assign o_zone.ending_kind     = r_ok;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_zone.ready |=> r_ov && $stable(r_oz))
        else $error("held zone changed");
    a_zone_no_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_za |-> r_wc == 2'd0)
        else $error("window not empty in zone");
    a_end_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_bar.series_end |=> r_cnt == '0 && !r_za && !r_pv)
        else $error("series end did not reset");
    a_emit_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_ok != 2'd3)
        else $error("bad ending");
`endif
endmodule
// ----------------------------------------------------------------------------

[tb/sv/ppzd_zone_checker.sv]
// ----------------------------------------------------------------------------
// ppzd_zone_checker
// Watches the bar and zone channels, tracks pivots, segments and zones on
// every bar beat, and compares each zone beat with the oldest predicted zone.
// ----------------------------------------------------------------------------
module ppzd_zone_checker #(
    parameter int INDEX_BITS = 24,
    parameter int PRICE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppzd_bar_if         bar,
    ppzd_zone_if        zone,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_beat_seen
);
    import ppzd_pkg::*;

    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [PRICE_BITS-1:0] price_t;
    localparam price_t PRICE_ONES = '1;

    typedef struct packed {
        idx_t   s, e;
        price_t hi, lo, inmax, inmin, ehi, elo;
        logic   down;
    } segment_t;

    typedef struct packed {
        idx_t       start_bar, end_bar;
        price_t     top, bottom, peak, trough;
        logic       down;
        logic [1:0] ending;
    } zone_t;

    idx_t     bar_idx;
    logic     piv_valid, piv_is_low;
    idx_t     piv_idx;
    price_t   piv_hi, piv_lo, gap_hi, gap_lo;
    segment_t win [3];
    int       win_count;
    logic     in_zone;
    idx_t     zs, ze;
    price_t   ztop, zbot, zpeak, ztrough, zehi, zelo;
    logic     zdown;
    zone_t    expected_zones [$];
    int       fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_zones.size();
    assign o_beat_seen  = (bar.valid && bar.ready) || (zone.valid && zone.ready);

    function automatic price_t pmax(price_t a, price_t b);
        return a > b ? a : b;
    endfunction
    function automatic price_t pmin(price_t a, price_t b);
        return a < b ? a : b;
    endfunction

    task automatic clear_series();
        bar_idx   = '0;
        piv_valid = 1'b0;
        piv_is_low = 1'b0;
        gap_hi    = '0;
        gap_lo    = PRICE_ONES;
        win_count = 0;
        in_zone   = 1'b0;
    endtask

    function automatic zone_t pack_zone(logic [1:0] ending);
        zone_t z;
        z.start_bar = zs;
        z.end_bar   = ze;
        z.top       = ztop;
        z.bottom    = zbot;
        z.peak      = zpeak;
        z.trough    = ztrough;
        z.down      = zdown;
        z.ending    = ending;
        return z;
    endfunction

    // Fold one segment into the window; returns 1 if it closed a zone.
    task automatic fold_segment(input segment_t g, output bit closed);
        price_t     nl, nh, ol, oh;
        logic [1:0] ending;
        closed = 0;
        if (in_zone) begin
            nl = pmax(zbot, g.lo);
            nh = pmin(ztop, g.hi);
            if (nl <= nh) begin
                zpeak   = pmax(pmax(zpeak, zehi), g.inmax);
                ztrough = pmin(pmin(ztrough, zelo), g.inmin);
                zbot = nl; ztop = nh; ze = g.e; zehi = g.ehi; zelo = g.elo;
            end else begin
                ending = END_OPEN;
                if (g.hi < zbot) ending = END_DOWN;
                else if (g.lo > ztop) ending = END_UP;
                expected_zones.insert(expected_zones.size(), pack_zone(ending));
                in_zone = 1'b0;
                win[0] = g;
                win_count = 1;
                closed = 1;
            end
            return;
        end
        if (win_count > 2) win_count = 2;
        win[win_count] = g;
        win_count++;
        if (win_count == 3) begin
            ol = pmax(pmax(win[0].lo, win[1].lo), win[2].lo);
            oh = pmin(pmin(win[0].hi, win[1].hi), win[2].hi);
            if (ol <= oh) begin
                zs = win[0].s; ze = win[2].e; ztop = oh; zbot = ol;
                zpeak = pmax(pmax(pmax(win[0].inmax, win[0].ehi),
                                  pmax(win[1].inmax, win[1].ehi)), win[2].inmax);
                ztrough = pmin(pmin(pmin(win[0].inmin, win[0].elo),
                                    pmin(win[1].inmin, win[1].elo)), win[2].inmin);
                zehi = win[2].ehi; zelo = win[2].elo; zdown = win[1].down;
                in_zone = 1'b1;
                win_count = 0;
            end else begin
                win[0] = win[1];
                win[1] = win[2];
                win_count = 2;
            end
        end
    endtask

    task automatic take_bar(logic [1:0] kind, price_t hi, price_t lo, logic last);
        segment_t g;
        bit       closed;
        idx_t     idx;
        idx = bar_idx;
        bar_idx = bar_idx + idx_t'(1);
        closed = 0;
        if (kind == PIVOT_HIGH || kind == PIVOT_LOW) begin
            if (piv_valid) begin
                g.s = piv_idx; g.e = idx;
                g.hi = pmax(piv_hi, hi); g.lo = pmin(piv_lo, lo);
                g.inmax = gap_hi; g.inmin = gap_lo;
                g.ehi = hi; g.elo = lo;
                g.down = !piv_is_low;
                fold_segment(g, closed);
            end
            piv_valid = 1'b1; piv_is_low = (kind == PIVOT_LOW);
            piv_idx = idx; piv_hi = hi; piv_lo = lo;
            gap_hi = '0; gap_lo = PRICE_ONES;
        end else begin
            gap_hi = pmax(gap_hi, hi);
            gap_lo = pmin(gap_lo, lo);
        end
        if (last) begin
            if (in_zone && !closed)
                expected_zones.insert(expected_zones.size(), pack_zone(END_OPEN));
            clear_series();
        end
    endtask

    task automatic check_zone();
        zone_t got, want;
        got.start_bar = zone.zone_start_bar;
        got.end_bar   = zone.zone_end_bar;
        got.top       = zone.zone_top;
        got.bottom    = zone.zone_bottom;
        got.peak      = zone.inner_peak;
        got.trough    = zone.inner_trough;
        got.down      = zone.middle_dir_down;
        got.ending    = zone.ending_kind;
        if (expected_zones.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected zone beat: %p", got);
            return;
        end
        want = expected_zones.pop_front();
        if (got !== want) begin
            fails++;
            if (fails <= 10) $display("zone mismatch\n  expected %p\n  actual   %p", want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_series();
            expected_zones.delete();
            fails = 0;
        end else begin
            // Zone beat compared before the bar beat of the same edge: the
            // block registers its zone output, so it cannot belong to this bar.
            if (zone.valid && zone.ready) check_zone();
            if (bar.valid && bar.ready)
                take_bar(bar.pivot_kind, bar.bar_high, bar.bar_low, bar.series_end);
        end
    end
endmodule
// ----------------------------------------------------------------------------

[tb/sv/tb_price_pivot_zone_detector.sv]
// ----------------------------------------------------------------------------
// tb_price_pivot_zone_detector
// Drives bar streams into the zone detector with random idling on both sides
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_price_pivot_zone_detector;
    import ppzd_pkg::*;

    localparam int INDEX_BITS = 24;
    localparam int PRICE_BITS = 32;
    localparam int NUM_BARS   = 1750;
    localparam int IDLE_LIMIT = 20000;  // cycles with no beat at all

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ppzd_bar_if  #(.PRICE_BITS(PRICE_BITS)) bar_ch ();
    ppzd_zone_if #(.INDEX_BITS(INDEX_BITS), .PRICE_BITS(PRICE_BITS)) zone_ch ();

    int   fail_count, pending;
    logic beat_seen;

    price_pivot_zone_detector #(.INDEX_BITS(INDEX_BITS), .PRICE_BITS(PRICE_BITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_bar  (bar_ch.sink),
        .o_zone (zone_ch.source)
    );

    ppzd_zone_checker #(.INDEX_BITS(INDEX_BITS), .PRICE_BITS(PRICE_BITS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .bar         (bar_ch),
        .zone        (zone_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_beat_seen (beat_seen)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bar descriptor handed from the generator to the driver.
    typedef struct {
        logic [1:0]            kind;
        logic [PRICE_BITS-1:0] hi, lo;
        logic                  last;
    } bar_t;

    bar_t bar_queue [$];
    bit   quiet_tail;     // no idling at all once set
    bit   hold_sink;      // long receiver hold-off request
    bit   stim_done;

    initial begin
        bar_ch.valid      = 1'b0;
        bar_ch.pivot_kind = PIVOT_NONE;
        bar_ch.bar_high   = '0;
        bar_ch.bar_low    = '0;
        bar_ch.series_end = 1'b0;
        zone_ch.ready     = 1'b0;
    end

    function automatic logic [PRICE_BITS-1:0] rand_price();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return PRICE_BITS'($urandom);
            default: return PRICE_BITS'(1000 + $urandom_range(0, 200));
        endcase
    endfunction

    task automatic add_bar(logic [1:0] kind, logic [PRICE_BITS-1:0] hi,
                           logic [PRICE_BITS-1:0] lo, logic last);
        bar_t b;
        b.kind = kind; b.hi = hi; b.lo = lo; b.last = last;
        bar_queue.insert(bar_queue.size(), b);
    endtask

    // A mostly well-formed swing: alternating pivots with up to three mostly plain
    // bars between, prices drifting around a center so zones form and break often.
    task automatic add_swing_series(int pivots);
        int unsigned center, h, l, gap;
        logic        high_side;
        center    = $urandom_range(500, 1500);
        high_side = $urandom_range(0, 1);
        for (int p = 0; p < pivots; p++) begin
            gap = $urandom_range(0, 3);
            for (int g = 0; g < gap; g++) begin
                l = center + $urandom_range(0, 40) - 20;
                add_bar($urandom_range(0, 7) == 0 ? 2'd3 : PIVOT_NONE,
                        l + $urandom_range(0, 10), l, 1'b0);
            end
            if ($urandom_range(0, 4) == 0) center = center + $urandom_range(0, 160) - 80;
            h = center + (high_side ? $urandom_range(10, 60) : $urandom_range(0, 10));
            l = center - (high_side ? $urandom_range(0, 10) : $urandom_range(10, 60));
            if ($urandom_range(0, 30) == 0) add_bar(high_side ? PIVOT_HIGH : PIVOT_LOW, l, h, 1'b0);
            else add_bar(high_side ? PIVOT_HIGH : PIVOT_LOW, h, l, 1'b0);
            high_side = !high_side;
        end
        add_bar(PIVOT_NONE, center, center, 1'b1);
    endtask

    task automatic build_stimulus();
        // Directed: short series without a zone, then an open zone at series end.
        add_bar(PIVOT_HIGH, '1, '0, 1'b0);
        add_bar(PIVOT_LOW, 32'd10, 32'd0, 1'b0);
        add_bar(PIVOT_HIGH, 32'd20, 32'd5, 1'b1);          // short series
        add_bar(PIVOT_HIGH, 32'd100, 32'd90, 1'b0);
        add_bar(PIVOT_NONE, '1, '0, 1'b0);
        add_bar(PIVOT_LOW, 32'd60, 32'd50, 1'b0);
        add_bar(2'd3, 32'd77, 32'd3, 1'b0);                 // unknown code
        add_bar(PIVOT_HIGH, 32'd95, 32'd85, 1'b0);
        add_bar(PIVOT_LOW, 32'd55, 32'd45, 1'b0);
        add_bar(PIVOT_HIGH, 32'd92, 32'd80, 1'b1);          // open at end
        // Zone left downward.
        add_bar(PIVOT_LOW, 32'd50, 32'd40, 1'b0);
        add_bar(PIVOT_HIGH, 32'd90, 32'd80, 1'b0);
        add_bar(PIVOT_LOW, 32'd52, 32'd42, 1'b0);
        add_bar(PIVOT_HIGH, 32'd88, 32'd78, 1'b0);
        add_bar(PIVOT_LOW, 32'd20, 32'd10, 1'b0);
        add_bar(PIVOT_HIGH, 32'd30, 32'd25, 1'b0);
        add_bar(PIVOT_LOW, 32'd40, 32'd35, 1'b1);
        // Inverted bar data as the last bar of a series with an open zone.
        add_bar(PIVOT_HIGH, 32'd90, 32'd80, 1'b0);
        add_bar(PIVOT_LOW, 32'd50, 32'd40, 1'b0);
        add_bar(PIVOT_HIGH, 32'd91, 32'd81, 1'b0);
        add_bar(PIVOT_LOW, 32'd51, 32'd41, 1'b0);
        add_bar(PIVOT_HIGH, 32'd10, 32'd200, 1'b1);
        // Random: mostly swing series, some noise and raw random bars.
        while (bar_queue.size() < NUM_BARS) begin
            case ($urandom_range(0, 9))
                0: add_bar(2'($urandom_range(0, 3)), PRICE_BITS'($urandom),
                           PRICE_BITS'($urandom), $urandom_range(0, 15) == 0);
                1: add_bar(2'($urandom_range(0, 3)), rand_price(), rand_price(), 1'b0);
                default: add_swing_series($urandom_range(2, 30));
            endcase
        end
    endtask

    // Sender: random idle bursts, none during the last part of the run.
    initial begin : sender
        int idle;
        bar_t b;
        build_stimulus();
        @(posedge i_clk iff i_rst_n);
        while (bar_queue.size() > 0) begin
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                idle = $urandom_range(1, 19);
                bar_ch.valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            b = bar_queue.pop_front();
            bar_ch.valid      <= 1'b1;
            bar_ch.pivot_kind <= b.kind;
            bar_ch.bar_high   <= b.hi;
            bar_ch.bar_low    <= b.lo;
            bar_ch.series_end <= b.last;
            @(posedge i_clk iff bar_ch.ready);
            if (bar_queue.size() < 300) quiet_tail = 1;
        end
        bar_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stall bursts, one long hold-off early on.
    initial begin : receiver
        int idle;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_sink) begin
                zone_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_sink = 0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                idle = $urandom_range(1, 19);
                zone_ch.ready <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end else begin
                zone_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (200) @(posedge i_clk);
        hold_sink = 1;
    end

    // Reset, then wait for drain or watchdog.
    initial begin : control
        int quiet;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        quiet = 0;
        while (!(stim_done && pending == 0)) begin
            @(posedge i_clk);
            quiet = beat_seen ? 0 : quiet + 1;
            if (quiet >= IDLE_LIMIT) begin
                $display("[price_pivot_zone_detector] ERROR");
                $finish;
            end
        end
        // Wait on to catch stray zone beats.
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[price_pivot_zone_detector] OK");
        end else begin
            $display("[price_pivot_zone_detector] ERROR");
        end
        $finish;
    end
endmodule
// ----------------------------------------------------------------------------

[files.f]
src/ppzd_pkg.sv
src/ppzd_bar_if.sv
src/ppzd_zone_if.sv
src/price_pivot_zone_detector.sv
tb/sv/ppzd_zone_checker.sv
tb/sv/tb_price_pivot_zone_detector.sv
